// ----- rtl/core/jdlp_pkg.sv -----
package jdlp_pkg;

  // Register file
  localparam int unsigned CFG_W           = 16;
  localparam int unsigned APB_DATA_W      = 32;
  localparam int unsigned APB_ADDR_W      = 3;
  localparam logic [0:0]  REG_DEBOUNCE    = 1'b0;
  localparam logic [0:0]  REG_LONG_PRESS  = 1'b1;
  localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd50;
  localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd1000;

  // Stream payloads
  localparam int unsigned NUM_DIRS  = 4;
  localparam int unsigned NUM_LINES = 5;
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 8;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_ticks;
    logic [CFG_W-1:0] long_press_ticks;
  } cfg_t;

  typedef struct packed {
    logic select_ev;
    logic back_ev;
  } center_ev_t;

endpackage

// ----- rtl/core/jdlp_dir_lane.sv -----
module jdlp_dir_lane
  import jdlp_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic step,
  input  logic pressed,
  input  cfg_t cfg,
  output logic press_ev
);

  localparam int unsigned CMP_W = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;

  logic                   raw_r,    raw_nxt;
  logic                   stable_r, stable_nxt;
  logic                   edge_r,   edge_nxt;
  logic [COUNT_WIDTH-1:0] cnt_r,    cnt_nxt;
  logic                   settled;
  logic                   edge_mid;

  // Restart the settle count on a raw change, else advance and saturate
  always_comb begin
    raw_nxt = pressed;
    if (pressed != raw_r) begin
      cnt_nxt = '0;
    end else if (cnt_r == {COUNT_WIDTH{1'b1}}) begin
      cnt_nxt = cnt_r;
    end else begin
      cnt_nxt = cnt_r + 1'b1;
    end
    settled = CMP_W'(cnt_nxt) >= CMP_W'(cfg.debounce_ticks);
  end

  // Take the stable level and flag the press edge once
  always_comb begin
    stable_nxt = stable_r;
    edge_mid   = edge_r;
    edge_nxt   = edge_r;
    press_ev   = 1'b0;
    if (settled) begin
      if (stable_r != pressed) begin
        stable_nxt = pressed;
        edge_mid   = 1'b0;
      end
      edge_nxt = edge_mid;
      if (stable_nxt && !edge_mid) begin
        edge_nxt = 1'b1;
        press_ev = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_r    <= 1'b0;
      stable_r <= 1'b0;
      edge_r   <= 1'b0;
      cnt_r    <= '0;
    end else if (step) begin
      raw_r    <= raw_nxt;
      stable_r <= stable_nxt;
      edge_r   <= edge_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ----- rtl/core/jdlp_center_lane.sv -----
module jdlp_center_lane
  import jdlp_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step,
  input  logic       pressed,
  input  cfg_t       cfg,
  output center_ev_t ev
);

  localparam int unsigned CMP_W = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;

  logic                   raw_r,    raw_nxt;
  logic                   stable_r, stable_nxt;
  logic                   fired_r,  fired_nxt;
  logic [COUNT_WIDTH-1:0] cnt_r,    cnt_nxt;
  logic [COUNT_WIDTH-1:0] hold_r,   hold_nxt;
  logic [COUNT_WIDTH-1:0] hold_inc;
  logic                   settled;

  // Settle counter, as in the direction lanes
  always_comb begin
    raw_nxt = pressed;
    if (pressed != raw_r) begin
      cnt_nxt = '0;
    end else if (cnt_r == {COUNT_WIDTH{1'b1}}) begin
      cnt_nxt = cnt_r;
    end else begin
      cnt_nxt = cnt_r + 1'b1;
    end
    settled = CMP_W'(cnt_nxt) >= CMP_W'(cfg.debounce_ticks);
  end

  // Advance hold time while stably pressed, also on unsettled ticks
  always_comb begin
    hold_inc = hold_r;
    if (stable_r && (hold_r != {COUNT_WIDTH{1'b1}})) begin
      hold_inc = hold_r + 1'b1;
    end
  end

  // Release before long press gives select; long hold gives back once
  always_comb begin
    stable_nxt   = stable_r;
    fired_nxt    = fired_r;
    hold_nxt     = hold_inc;
    ev.select_ev = 1'b0;
    ev.back_ev   = 1'b0;
    if (settled) begin
      if (pressed != stable_r) begin
        ev.select_ev = !pressed && !fired_r;
        stable_nxt   = pressed;
        fired_nxt    = 1'b0;
        if (pressed) begin
          hold_nxt = '0;
        end
      end
      if (stable_nxt && !fired_nxt &&
          (CMP_W'(hold_nxt) >= CMP_W'(cfg.long_press_ticks))) begin
        fired_nxt  = 1'b1;
        ev.back_ev = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_r    <= 1'b0;
      stable_r <= 1'b0;
      fired_r  <= 1'b0;
      cnt_r    <= '0;
      hold_r   <= '0;
    end else if (step) begin
      raw_r    <= raw_nxt;
      stable_r <= stable_nxt;
      fired_r  <= fired_nxt;
      cnt_r    <= cnt_nxt;
      hold_r   <= hold_nxt;
    end
  end

endmodule

// ----- rtl/core/jdlp_merge.sv -----
module jdlp_merge
  import jdlp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  logic [NUM_DIRS-1:0]   dir_ev,
  input  center_ev_t            center_ev,
  input  logic [NUM_LINES-1:0]  pressed,
  input  logic                  out_tready,
  output logic                  out_tvalid,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  logic                  valid_r, valid_nxt;
  logic [OUT_DATA_W-1:0] data_r;
  logic [OUT_DATA_W-1:0] data_nxt;

  // Pack the lane events and the raw any-pressed flag into one item
  always_comb begin
    data_nxt = {1'b0, |pressed, center_ev.back_ev, center_ev.select_ev, dir_ev};
  end

  // Load a new item on step, drop the held one once taken
  always_comb begin
    valid_nxt = valid_r;
    if (step) begin
      valid_nxt = 1'b1;
    end else if (out_tready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      data_r <= data_nxt;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;

endmodule

// ----- rtl/core/joystick_debounce_long_press_core.sv -----
// Channel  Direction  Handshake               Payload
// in_      slave      in_tvalid / in_tready   in_tdata: one tick of five line levels
// out_     master     out_tvalid / out_tready out_tdata: events and any_pressed
// cfg_     APB slave  psel, penable, pready   debounce_ticks @0x0, long_press_ticks @0x4
//
// One item per cycle unless the output stalls: all five lanes update in the cycle
// the item is accepted. The output register presents the result in the next cycle.
// in_tready is high whenever the output register is empty or being taken.
// Synchronous active-low reset clears all lane state; registers return to 50 / 1000.
module joystick_debounce_long_press_core
  import jdlp_pkg::*;
#(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [0] up_n, [1] down_n, [2] left_n, [3] right_n, [4] center_n
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [0] up_event, [1] down_event, [2] left_event, [3] right_event,
  // [4] select_event, [5] back_event, [6] any_pressed
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [APB_ADDR_W-1:0] cfg_paddr,
  input  logic [APB_DATA_W-1:0] cfg_pwdata,
  output logic [APB_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  cfg_t                 cfg_r;
  logic                 step;
  logic [NUM_LINES-1:0] pressed;
  logic [NUM_DIRS-1:0]  dir_ev;
  center_ev_t           center_ev;
  logic                 cfg_wr;

  // Register writes
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.debounce_ticks   <= DEBOUNCE_RST;
      cfg_r.long_press_ticks <= LONG_PRESS_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_DEBOUNCE:   cfg_r.debounce_ticks   <= cfg_pwdata[CFG_W-1:0];
        REG_LONG_PRESS: cfg_r.long_press_ticks <= cfg_pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    case (cfg_paddr[2])
      REG_DEBOUNCE:   cfg_prdata = APB_DATA_W'(cfg_r.debounce_ticks);
      REG_LONG_PRESS: cfg_prdata = APB_DATA_W'(cfg_r.long_press_ticks);
      default:        cfg_prdata = '0;
    endcase
  end

  // Accept a tick whenever the output slot is free or draining
  assign in_tready = !out_tvalid || out_tready;
  assign step      = in_tvalid && in_tready;
  assign pressed   = ~in_tdata[NUM_LINES-1:0];

  // Direction lanes
  for (genvar g = 0; g < NUM_DIRS; g++) begin : g_dir
    jdlp_dir_lane #(
      .COUNT_WIDTH(COUNT_WIDTH)
    ) u_lane (
      .clk      (clk),
      .rst_n    (rst_n),
      .step     (step),
      .pressed  (pressed[g]),
      .cfg      (cfg_r),
      .press_ev (dir_ev[g])
    );
  end

  // Center lane
  jdlp_center_lane #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_center (
    .clk     (clk),
    .rst_n   (rst_n),
    .step    (step),
    .pressed (pressed[NUM_LINES-1]),
    .cfg     (cfg_r),
    .ev      (center_ev)
  );

  // Merge lane results into the output register
  jdlp_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (step),
    .dir_ev     (dir_ev),
    .center_ev  (center_ev),
    .pressed    (pressed),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata)
  );

  // Select and back never come from the same tick
  a_sel_back_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[4] && out_tdata[5]))
    else $error("select and back in one item");

  // A press or long-press event needs some line held low on that tick
  a_event_pressed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && ((|out_tdata[3:0]) || out_tdata[5])) |-> out_tdata[6])
    else $error("press event without any line low");

  // An empty output slot always takes the next tick
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("stalled with empty output");

  // An accepted tick is presented in the next cycle
  a_step_valid: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> out_tvalid)
    else $error("accepted tick not presented");

endmodule
